[design/packet_slot_ring_fifo_defines.svh]
// Assertion helpers used by the top-level design file.
`ifndef PACKET_SLOT_RING_FIFO_DEFINES_SVH
`define PACKET_SLOT_RING_FIFO_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PSRF_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

`define PSRF_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`else

`define PSRF_ASSERT_IMPLY(name, clk, rst, pre, post)

`define PSRF_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

[design/psrf_pkg.sv]
package psrf_pkg;

   localparam int SLOTS     = 16;
   localparam int MAX_BYTES = 512;
   localparam int WORDS     = (MAX_BYTES + 7) / 8;

   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int PTR_W     = SLOT_W + 1;
   localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WCNT_W    = WIDX_W + 1;
   localparam int RAM_AW    = SLOT_W + WIDX_W;
   localparam int RAM_DEPTH = SLOTS * (2 ** WIDX_W);

   localparam int PLEN_W    = 12;
   localparam int LEN_W     = 10;
   localparam int CAP_W     = 16;
   localparam int DATA_W    = 64;
   localparam int TIME_W    = 64;
   localparam int OCC_W     = 5;
   localparam int CNT_W     = 32;
   localparam int NBYTES    = DATA_W / 8;

   // both queue depths are powers of two so the pointers wrap naturally
   localparam int MQ_DEPTH  = 2;
   localparam int MQ_PTR_W  = $clog2(MQ_DEPTH);
   localparam int MQ_CNT_W  = $clog2(MQ_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic {
      CMD_ENQ = 1'b0,
      CMD_DEQ = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LONG  = 3'd1,
      ST_FULL_DROP = 3'd2,
      ST_FULL_WAIT = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_TOO_SMALL = 3'd5
   } status_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [PLEN_W-1:0]      pkt_len;
      logic [TIME_W-1:0]      capture_time;
      logic [DATA_W-1:0]      payload_word;
      logic                   word_last;
      logic [CAP_W-1:0]       out_capacity;
      logic                   want_payload;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [LEN_W-1:0]       result_len;
      logic [TIME_W-1:0]      result_time;
      logic [DATA_W-1:0]      result_word;
      logic                   last;
      logic [OCC_W-1:0]       occupancy;
      logic [CNT_W-1:0]       drop_count;
      logic [CNT_W-1:0]       wait_count;
      logic [CNT_W-1:0]       enq_count;
      logic [CNT_W-1:0]       deq_count;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]       drop_count;
      logic [CNT_W-1:0]       wait_count;
      logic [CNT_W-1:0]       enq_count;
      logic [CNT_W-1:0]       deq_count;
   } stats_type;

   // one classified word handed from front to back
   typedef struct packed {
      logic                   stream;
      status_type             status;
      logic [LEN_W-1:0]       len;
      logic [TIME_W-1:0]      ptime;
      logic [SLOT_W-1:0]      slot;
      logic [WCNT_W-1:0]      nwords;
      logic [WCNT_W-1:0]      wcount;
      logic [OCC_W-1:0]       occupancy;
      stats_type              stats;
   } mq_entry_type;

   typedef struct packed {
      logic                   en;
      logic [RAM_AW-1:0]      addr;
      logic [DATA_W-1:0]      data;
   } ram_wr_type;

   typedef struct packed {
      logic                   en;
      logic [RAM_AW-1:0]      addr;
   } ram_rd_type;

endpackage

[design/psrf_ram.sv]
module psrf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/psrf_front.sv]
module psrf_front import psrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_type      req_word,
   output logic         full,
   input  logic         csr_we,
   input  logic         csr_wdata,
   input  logic         mq_full,
   output logic         mq_push,
   output mq_entry_type mq_entry,
   input  logic         stream_done,
   output ram_wr_type   ram_wr
);

   function automatic logic [WCNT_W-1:0] words_of(input logic [LEN_W-1:0] len);
      logic [LEN_W:0] sum;
      sum = {1'b0, len} + (LEN_W+1)'(7);
      return WCNT_W'(sum >> 3);
   endfunction

   logic [PTR_W-1:0]  rp_ff, rp_in, wp_ff, wp_in;
   logic              in_pkt_ff, in_pkt_in, acc_ff, acc_in;
   logic [WCNT_W-1:0] widx_ff, widx_in;
   logic [LEN_W-1:0]  enq_len_ff, enq_len_in;
   stats_type         stats_ff, stats_in;
   logic              block_ff, block_in;
   logic [1:0]        scnt_ff, scnt_in;

   // per-slot metadata; wcount is how many words were really written
   logic [LEN_W-1:0]  len_mem_ff  [SLOTS];
   logic [TIME_W-1:0] time_mem_ff [SLOTS];
   logic [WCNT_W-1:0] wcnt_mem_ff [SLOTS];

   logic              accept, meta_we, wcnt_we, store;
   logic [PTR_W-1:0]  fill;
   logic [SLOT_W-1:0] wslot, rslot;
   logic [LEN_W-1:0]  cur_len, dq_len;
   logic [WCNT_W-1:0] cur_idx, idx_next;

   // outside an open packet, every word waits until no payload stream reads the ring
   assign full   = mq_full || (!in_pkt_ff && (scnt_ff != 2'd0));
   assign accept = push && !full;
   assign fill   = wp_ff - rp_ff;
   assign wslot  = wp_ff[SLOT_W-1:0];
   assign rslot  = rp_ff[SLOT_W-1:0];
   assign dq_len = len_mem_ff[rslot];

   assign cur_len  = in_pkt_ff ? enq_len_ff : req_word.pkt_len[LEN_W-1:0];
   assign cur_idx  = in_pkt_ff ? widx_ff : '0;
   assign store    = cur_idx < words_of(cur_len);
   assign idx_next = store ? WCNT_W'(cur_idx + 1'b1) : cur_idx;

   always_comb begin
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      in_pkt_in  = in_pkt_ff;
      acc_in     = acc_ff;
      widx_in    = widx_ff;
      enq_len_in = enq_len_ff;
      stats_in   = stats_ff;
      meta_we    = 1'b0;
      wcnt_we    = 1'b0;
      mq_push    = 1'b0;
      ram_wr.en   = 1'b0;
      ram_wr.addr = {wslot, cur_idx[WIDX_W-1:0]};
      ram_wr.data = req_word.payload_word;

      mq_entry.stream = 1'b0;
      mq_entry.status = ST_OK;
      mq_entry.len    = '0;
      mq_entry.ptime  = '0;
      mq_entry.slot   = rslot;
      mq_entry.nwords = words_of(dq_len);
      mq_entry.wcount = wcnt_mem_ff[rslot];

      if (accept) begin
         if (req_word.cmd == CMD_ENQ) begin
            if (in_pkt_ff) begin
               if (!acc_ff) begin
                  // tail of a rejected packet: swallowed silently
                  if (req_word.word_last) begin
                     in_pkt_in = 1'b0;
                  end
               end else begin
                  mq_push   = 1'b1;
                  ram_wr.en = store;
                  widx_in   = idx_next;
                  if (req_word.word_last) begin
                     wcnt_we   = 1'b1;
                     wp_in     = wp_ff + 1'b1;
                     stats_in.enq_count = stats_ff.enq_count + 1'b1;
                     in_pkt_in = 1'b0;
                     acc_in    = 1'b0;
                     widx_in   = '0;
                  end
               end
            end else if (req_word.pkt_len > PLEN_W'(MAX_BYTES)) begin
               mq_push         = 1'b1;
               mq_entry.status = ST_TOO_LONG;
               if (!req_word.word_last) begin
                  in_pkt_in = 1'b1;
                  acc_in    = 1'b0;
               end
            end else if (fill >= PTR_W'(SLOTS)) begin
               mq_push = 1'b1;
               if (block_ff) begin
                  mq_entry.status     = ST_FULL_WAIT;
                  stats_in.wait_count = stats_ff.wait_count + 1'b1;
               end else begin
                  mq_entry.status     = ST_FULL_DROP;
                  stats_in.drop_count = stats_ff.drop_count + 1'b1;
                  if (!req_word.word_last) begin
                     in_pkt_in = 1'b1;
                     acc_in    = 1'b0;
                  end
               end
            end else begin
               mq_push    = 1'b1;
               meta_we    = 1'b1;
               enq_len_in = req_word.pkt_len[LEN_W-1:0];
               ram_wr.en  = store;
               if (req_word.word_last) begin
                  wcnt_we = 1'b1;
                  wp_in   = wp_ff + 1'b1;
                  stats_in.enq_count = stats_ff.enq_count + 1'b1;
                  widx_in = '0;
               end else begin
                  in_pkt_in = 1'b1;
                  acc_in    = 1'b1;
                  widx_in   = idx_next;
               end
            end
         end else begin
            mq_push = 1'b1;
            if (fill == '0) begin
               mq_entry.status = ST_EMPTY;
            end else if (req_word.want_payload &&
                         (req_word.out_capacity < CAP_W'(dq_len))) begin
               mq_entry.status = ST_TOO_SMALL;
               mq_entry.len    = dq_len;
               mq_entry.ptime  = time_mem_ff[rslot];
            end else begin
               mq_entry.len    = dq_len;
               mq_entry.ptime  = time_mem_ff[rslot];
               mq_entry.stream = req_word.want_payload && (words_of(dq_len) != '0);
               rp_in = rp_ff + 1'b1;
               stats_in.deq_count = stats_ff.deq_count + 1'b1;
            end
         end
      end

      mq_entry.occupancy = OCC_W'(wp_in - rp_in);
      mq_entry.stats     = stats_in;
   end

   always_comb begin
      scnt_in = scnt_ff;
      if (mq_push && mq_entry.stream) begin
         scnt_in = scnt_in + 2'd1;
      end
      if (stream_done) begin
         scnt_in = scnt_in - 2'd1;
      end
      block_in = csr_we ? csr_wdata : block_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff      <= '0;
         wp_ff      <= '0;
         in_pkt_ff  <= 1'b0;
         acc_ff     <= 1'b0;
         widx_ff    <= '0;
         stats_ff   <= '0;
         block_ff   <= 1'b0;
         scnt_ff    <= '0;
      end else begin
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         in_pkt_ff  <= in_pkt_in;
         acc_ff     <= acc_in;
         widx_ff    <= widx_in;
         stats_ff   <= stats_in;
         block_ff   <= block_in;
         scnt_ff    <= scnt_in;
      end
   end

   always_ff @(posedge clock) begin
      enq_len_ff <= enq_len_in;
      if (meta_we) begin
         len_mem_ff[wslot]  <= req_word.pkt_len[LEN_W-1:0];
         time_mem_ff[wslot] <= req_word.capture_time;
      end
      if (wcnt_we) begin
         wcnt_mem_ff[wslot] <= idx_next;
      end
   end

endmodule

[design/psrf_back.sv]
module psrf_back import psrf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              mq_valid,
   input  mq_entry_type      mq_head,
   output logic              mq_pop,
   output logic              stream_done,
   output ram_rd_type        ram_rd,
   input  logic [DATA_W-1:0] ram_rd_data,
   output logic              empty,
   input  logic              pop,
   output rsp_type           rsp_word
);

   logic [WCNT_W-1:0]    k_ff, k_in;
   logic                 s1_valid_ff;
   rsp_type              s1_rsp_ff, s1_rsp_in;
   logic                 s1_use_ff, s1_use_in;
   logic [NBYTES-1:0]    s1_keep_ff, s1_keep_in;

   rsp_type              ofifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] owp_ff, orp_ff;
   logic [OUT_CNT_W-1:0] ocnt_ff;

   logic                 issue, last_k, opop;
   logic [OUT_CNT_W:0]   pending;
   logic [LEN_W-1:0]     rem;
   logic [DATA_W-1:0]    out_word;
   rsp_type              out_rsp;

   // entries in the output queue plus the one in flight never pass its depth
   assign pending = (OUT_CNT_W+1)'(ocnt_ff) + (OUT_CNT_W+1)'(s1_valid_ff);
   assign issue   = mq_valid && (pending < (OUT_CNT_W+1)'(OUT_DEPTH));
   assign last_k  = (WCNT_W'(k_ff + 1'b1) == mq_head.nwords);
   assign rem     = mq_head.len - LEN_W'({k_ff, 3'b000});

   assign mq_pop      = issue && (!mq_head.stream || last_k);
   assign stream_done = mq_pop && mq_head.stream;

   assign ram_rd.en   = issue && mq_head.stream;
   assign ram_rd.addr = {mq_head.slot, k_ff[WIDX_W-1:0]};

   always_comb begin
      k_in = k_ff;
      if (issue && mq_head.stream) begin
         k_in = last_k ? '0 : WCNT_W'(k_ff + 1'b1);
      end

      s1_rsp_in.status      = mq_head.status;
      s1_rsp_in.result_len  = mq_head.len;
      s1_rsp_in.result_time = mq_head.ptime;
      s1_rsp_in.result_word = '0;
      s1_rsp_in.last        = !mq_head.stream || last_k;
      s1_rsp_in.occupancy   = mq_head.occupancy;
      s1_rsp_in.drop_count  = mq_head.stats.drop_count;
      s1_rsp_in.wait_count  = mq_head.stats.wait_count;
      s1_rsp_in.enq_count   = mq_head.stats.enq_count;
      s1_rsp_in.deq_count   = mq_head.stats.deq_count;

      // words past the written count were padding; bytes past the length read zero
      s1_use_in = mq_head.stream && (k_ff < mq_head.wcount);
      for (int b = 0; b < NBYTES; b++) begin
         s1_keep_in[b] = rem > LEN_W'(b);
      end
   end

   always_comb begin
      for (int b = 0; b < NBYTES; b++) begin
         out_word[8*b +: 8] = (s1_use_ff && s1_keep_ff[b]) ? ram_rd_data[8*b +: 8] : 8'h00;
      end
      out_rsp             = s1_rsp_ff;
      out_rsp.result_word = out_word;
   end

   assign empty    = (ocnt_ff == '0);
   assign opop     = pop && !empty;
   assign rsp_word = ofifo_ff[orp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
         owp_ff      <= '0;
         orp_ff      <= '0;
         ocnt_ff     <= '0;
      end else begin
         k_ff        <= k_in;
         s1_valid_ff <= issue;
         if (s1_valid_ff) begin
            owp_ff <= owp_ff + 1'b1;
         end
         if (opop) begin
            orp_ff <= orp_ff + 1'b1;
         end
         ocnt_ff <= ocnt_ff + OUT_CNT_W'(s1_valid_ff) - OUT_CNT_W'(opop);
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_rsp_ff  <= s1_rsp_in;
         s1_use_ff  <= s1_use_in;
         s1_keep_ff <= s1_keep_in;
      end
      if (s1_valid_ff) begin
         ofifo_ff[owp_ff] <= out_rsp;
      end
   end

endmodule

[design/packet_slot_ring_fifo.sv]
// Packet ring of SLOTS slots, each with length, capture time and payload words.
// Enqueue words are taken one per cycle while full is low; each accepted word
// that is not the ignored tail of a rejected packet gives one response word. A
// dequeue with payload streams one response word per cycle while the output
// queue has room, set by the single read port of the payload RAM. While such a
// stream is still reading the ring and no packet is open, full holds off every
// request word, so the first word of a new packet and any further dequeue wait;
// once a packet has started, its words and any dequeue sent meanwhile keep
// flowing. Responses carry the counters and occupancy as they stood right after
// their request. No clearing pass is needed after reset.
`include "packet_slot_ring_fifo_defines.svh"

module packet_slot_ring_fifo import psrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_word,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_word,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   mq_entry_type        mq_ff [MQ_DEPTH];
   logic [MQ_PTR_W-1:0] mq_wp_ff, mq_rp_ff;
   logic [MQ_CNT_W-1:0] mq_cnt_ff;

   logic                mq_push, mq_pop, mq_full, mq_valid, stream_done;
   mq_entry_type        mq_entry;
   ram_wr_type          ram_wr;
   ram_rd_type          ram_rd;
   logic [DATA_W-1:0]   ram_rd_data;

   assign mq_full  = (mq_cnt_ff == MQ_CNT_W'(MQ_DEPTH));
   assign mq_valid = (mq_cnt_ff != '0);

   psrf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_word    (req_word),
      .full        (full),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mq_full     (mq_full),
      .mq_push     (mq_push),
      .mq_entry    (mq_entry),
      .stream_done (stream_done),
      .ram_wr      (ram_wr)
   );

   // short queue between classification and response generation
   always_ff @(posedge clock) begin
      if (reset) begin
         mq_wp_ff  <= '0;
         mq_rp_ff  <= '0;
         mq_cnt_ff <= '0;
      end else begin
         if (mq_push) begin
            mq_wp_ff <= mq_wp_ff + 1'b1;
         end
         if (mq_pop) begin
            mq_rp_ff <= mq_rp_ff + 1'b1;
         end
         mq_cnt_ff <= mq_cnt_ff + MQ_CNT_W'(mq_push) - MQ_CNT_W'(mq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (mq_push) begin
         mq_ff[mq_wp_ff] <= mq_entry;
      end
   end

   psrf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rd_data)
   );

   psrf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .mq_valid    (mq_valid),
      .mq_head     (mq_ff[mq_rp_ff]),
      .mq_pop      (mq_pop),
      .stream_done (stream_done),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_word    (rsp_word)
   );

   `PSRF_ASSERT_IMPLY(a_mq_no_overflow, clock, reset, mq_push, !mq_full || mq_pop)
   `PSRF_ASSERT_IMPLY(a_mq_no_underflow, clock, reset, mq_pop, mq_valid)
   `PSRF_ASSERT_IMPLY(a_no_write_under_stream, clock, reset, ram_wr.en && ram_rd.en, ram_wr.addr != ram_rd.addr)
   `PSRF_ASSERT_NEXT(a_reset_queue_empty, clock, 1'b0, reset, empty && (mq_cnt_ff == '0))

endmodule

[dv/packet_slot_ring_fifo_test.sv]
`timescale 1ns / 100ps

module packet_slot_ring_fifo_test;
   import psrf_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int TAIL_CYCLES = 24;
   localparam int PHASES      = 6;
   localparam int PHASE_WORDS = 55;

   // Shadow of the packet ring: works out the response words of every word
   // taken on the request side and checks the response side against them.
   class ring_tracker;
      rsp_type           due_words[$];
      bit                hold_when_full = 1'b0;
      logic [PTR_W-1:0]  rd_ptr = '0;
      logic [PTR_W-1:0]  wr_ptr = '0;
      logic [LEN_W-1:0]  len_mem [SLOTS];
      logic [TIME_W-1:0] time_mem [SLOTS];
      logic [DATA_W-1:0] data_mem [SLOTS*WORDS];
      bit                in_pkt = 1'b0;
      bit                pkt_ok = 1'b0;
      int                widx = 0;
      logic [CNT_W-1:0]  drops = '0;
      logic [CNT_W-1:0]  waits = '0;
      logic [CNT_W-1:0]  enqs = '0;
      logic [CNT_W-1:0]  deqs = '0;
      status_type        latest = ST_OK;
      int                taken = 0;
      int                answered = 0;
      int                seen = 0;
      int                mismatches = 0;

      function int fill();
         logic [PTR_W-1:0] d;
         d = wr_ptr - rd_ptr;
         return int'(d);
      endfunction

      function int words_of(int len);
         return (len + 7) / 8;
      endfunction

      function void emit(status_type st, logic [LEN_W-1:0] len, logic [TIME_W-1:0] tm,
                         logic [DATA_W-1:0] w, bit lst);
         rsp_type e;
         e.status      = st;
         e.result_len  = len;
         e.result_time = tm;
         e.result_word = w;
         e.last        = lst;
         e.occupancy   = OCC_W'(fill());
         e.drop_count  = drops;
         e.wait_count  = waits;
         e.enq_count   = enqs;
         e.deq_count   = deqs;
         latest = st;
         due_words.push_back(e);
      endfunction

      function void store(logic [DATA_W-1:0] w);
         int slot;
         int n;
         slot = int'(wr_ptr[SLOT_W-1:0]);
         n = words_of(int'(len_mem[slot]));
         if (widx < n && widx < WORDS) begin
            data_mem[slot*WORDS + widx] = w;
            widx++;
         end
      endfunction

      // short packets get zero padding up to their length
      function void commit();
         int slot;
         int n;
         int i;
         slot = int'(wr_ptr[SLOT_W-1:0]);
         n = words_of(int'(len_mem[slot]));
         for (i = widx; i < n && i < WORDS; i++)
            data_mem[slot*WORDS + i] = '0;
         wr_ptr++;
         enqs++;
         in_pkt = 1'b0;
         pkt_ok = 1'b0;
         widx = 0;
      endfunction

      // returns the number of response words the request word causes
      function int take_word(req_type r);
         int slot;
         int n;
         int k;
         int rem;
         logic [LEN_W-1:0]  len;
         logic [TIME_W-1:0] tm;
         logic [DATA_W-1:0] w;
         taken++;
         if (r.cmd == CMD_ENQ) begin
            if (in_pkt) begin
               if (!pkt_ok) begin
                  // tail of a rejected packet
                  if (r.word_last)
                     in_pkt = 1'b0;
                  return 0;
               end
               store(r.payload_word);
               if (r.word_last)
                  commit();
               emit(ST_OK, '0, '0, '0, 1'b1);
               answered++;
               return 1;
            end
            answered++;
            if (int'(r.pkt_len) > MAX_BYTES) begin
               if (!r.word_last) begin
                  in_pkt = 1'b1;
                  pkt_ok = 1'b0;
               end
               emit(ST_TOO_LONG, '0, '0, '0, 1'b1);
               return 1;
            end
            if (fill() >= SLOTS) begin
               if (hold_when_full) begin
                  waits++;
                  emit(ST_FULL_WAIT, '0, '0, '0, 1'b1);
                  return 1;
               end
               drops++;
               if (!r.word_last) begin
                  in_pkt = 1'b1;
                  pkt_ok = 1'b0;
               end
               emit(ST_FULL_DROP, '0, '0, '0, 1'b1);
               return 1;
            end
            slot = int'(wr_ptr[SLOT_W-1:0]);
            len_mem[slot] = r.pkt_len[LEN_W-1:0];
            time_mem[slot] = r.capture_time;
            widx = 0;
            store(r.payload_word);
            if (r.word_last) begin
               commit();
            end else begin
               in_pkt = 1'b1;
               pkt_ok = 1'b1;
            end
            emit(ST_OK, '0, '0, '0, 1'b1);
            return 1;
         end
         answered++;
         if (fill() == 0) begin
            emit(ST_EMPTY, '0, '0, '0, 1'b1);
            return 1;
         end
         slot = int'(rd_ptr[SLOT_W-1:0]);
         len = len_mem[slot];
         tm = time_mem[slot];
         n = words_of(int'(len));
         if (r.want_payload && int'(r.out_capacity) < int'(len)) begin
            emit(ST_TOO_SMALL, len, tm, '0, 1'b1);
            return 1;
         end
         rd_ptr++;
         deqs++;
         if (!r.want_payload || n == 0) begin
            emit(ST_OK, len, tm, '0, 1'b1);
            return 1;
         end
         if (n > WORDS)
            n = WORDS;
         for (k = 0; k < n; k++) begin
            w = data_mem[slot*WORDS + k];
            rem = int'(len) - 8 * k;
            if (rem < 8)
               w &= (64'd1 << (8 * rem)) - 64'd1;
            emit(ST_OK, len, tm, w, k + 1 == n);
         end
         return n;
      endfunction

      task flag(string msg);
         mismatches++;
         $display("ERROR: %s", msg);
      endtask

      task cmp(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            flag($sformatf("response word %0d, %s: got %0h, expected %0h",
                           seen, name, got, want));
      endtask

      task match_word(rsp_type got);
         rsp_type want;
         seen++;
         if (due_words.size() == 0) begin
            flag($sformatf("response word %0d arrived with nothing outstanding", seen));
            return;
         end
         want = due_words.pop_front();
         cmp("status", got.status, want.status);
         cmp("result_len", got.result_len, want.result_len);
         cmp("result_time", got.result_time, want.result_time);
         cmp("result_word", got.result_word, want.result_word);
         cmp("last", got.last, want.last);
         cmp("occupancy", got.occupancy, want.occupancy);
         cmp("drop_count", got.drop_count, want.drop_count);
         cmp("wait_count", got.wait_count, want.wait_count);
         cmp("enq_count", got.enq_count, want.enq_count);
         cmp("deq_count", got.deq_count, want.deq_count);
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_word = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_word;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;

   ring_tracker tracker = new();
   rsp_type     popped[$];
   int          cycles = 0;
   int          tx_calm = 0;
   int          rx_calm = 0;

   packet_slot_ring_fifo u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // compare away from the clock edge so every word taken at that edge is in
   always @(negedge clock) begin
      while (popped.size() > 0)
         tracker.match_word(popped.pop_front());
   end

   // random gaps with occasional stretches of back-to-back traffic
   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 30) == 0)
         calm = $urandom_range(10, 40);
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = pick_gap(rx_calm);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         popped.push_back(rsp_word);
      end
   end

   task automatic send_word(input req_type r, output status_type st);
      int gap;
      int n;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (full);
      n = tracker.take_word(r);
      st = (n > 0) ? tracker.latest : ST_OK;
   endtask

   task automatic send_deq(input bit want, input logic [CAP_W-1:0] cap);
      req_type    r;
      status_type st;
      r = '0;
      r.cmd = CMD_DEQ;
      r.pkt_len = PLEN_W'($urandom);
      r.capture_time = rand64();
      r.payload_word = rand64();
      r.word_last = 1'($urandom);
      r.out_capacity = cap;
      r.want_payload = want;
      send_word(r, st);
   endtask

   // on a full-wait the first word goes again once a slot has been freed
   task automatic send_packet(input int len, input int nwords, input logic [63:0] tm);
      req_type    r;
      status_type st;
      int         i;
      r = '0;
      r.cmd = CMD_ENQ;
      r.pkt_len = PLEN_W'(len);
      r.capture_time = tm;
      for (i = 0; i < nwords; i++) begin
         r.payload_word = rand64();
         r.word_last = (i == nwords - 1);
         r.out_capacity = CAP_W'($urandom);
         r.want_payload = 1'($urandom);
         send_word(r, st);
         while (i == 0 && st == ST_FULL_WAIT) begin
            send_deq(1'b0, '0);
            send_word(r, st);
         end
      end
   endtask

   task automatic settle();
      push <= 1'b0;
      while (tracker.due_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit hold);
      csr_we <= 1'b1;
      csr_wdata <= hold;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.hold_when_full = hold;
   endtask

   task automatic random_step(input int enq_pct);
      int         pick;
      int         len;
      int         n;
      req_type    r;
      status_type st;
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            len = $urandom_range(MAX_BYTES + 1, 4095);
         else if (pick < 11)
            len = $urandom_range(65, MAX_BYTES);
         else if (pick < 13)
            len = MAX_BYTES;
         else if (pick < 30)
            len = $urandom_range(25, 64);
         else
            len = $urandom_range(0, 24);
         n = (len > MAX_BYTES) ? $urandom_range(1, 3) : (len + 7) / 8;
         if (n < 1)
            n = 1;
         pick = $urandom_range(0, 9);
         if (pick == 0 && n > 1)
            n = $urandom_range(1, n - 1);     // short, padded at commit
         else if (pick == 1)
            n = n + $urandom_range(1, 2);     // excess words are dropped
         send_packet(len, n, rand64());
      end else if (pick < 92) begin
         pick = $urandom_range(0, 9);
         send_deq($urandom_range(0, 4) != 0,
                  (pick < 2) ? CAP_W'($urandom_range(0, 600)) :
                  (pick == 2) ? CAP_W'($urandom) : '1);
      end else begin
         r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         send_word(r, st);
      end
   endtask

   initial begin
      int i;
      int p;
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);

      // directed: edge lengths, rejected and oddly sized packets, all dequeue outcomes
      send_deq(1'b1, '0);
      send_packet(0, 1, '1);
      send_packet(13, 2, '0);
      send_packet(MAX_BYTES, 2, rand64());
      send_packet(4095, 1, rand64());
      send_packet(MAX_BYTES + 1, 3, rand64());
      send_packet(8, 3, rand64());
      send_deq(1'b0, '0);
      send_deq(1'b1, '0);
      send_deq(1'b1, '1);
      send_deq(1'b1, CAP_W'(MAX_BYTES - 1));
      send_deq(1'b1, CAP_W'(MAX_BYTES));
      send_deq(1'b1, CAP_W'(8));
      send_deq(1'b1, '1);

      // fill the ring, then overflow it in both modes
      settle();
      for (i = 0; i < SLOTS; i++)
         send_packet($urandom_range(0, 8), 1, rand64());
      send_packet(16, 2, rand64());
      send_packet(4095, 1, rand64());
      settle();
      write_mode(1'b1);
      send_packet(8, 1, rand64());
      send_packet(20, 3, rand64());

      for (p = 0; p < PHASES; p++) begin
         settle();
         write_mode(p % 2 == 1);
         target = tracker.answered + PHASE_WORDS;
         while (tracker.answered < target)
            random_step((p % 3 == 0) ? 85 : 30);
      end

      settle();
      $display("covered %0d request words (%0d answered), %0d response words checked",
               tracker.taken, tracker.answered, tracker.seen);
      $display("packets enqueued %0d, dequeued %0d, dropped %0d, full waits %0d",
               tracker.enqs, tracker.deqs, tracker.drops, tracker.waits);
      if (tracker.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/psrf_pkg.sv
design/psrf_ram.sv
design/psrf_front.sv
design/psrf_back.sv
design/packet_slot_ring_fifo.sv
dv/packet_slot_ring_fifo_test.sv
